@@ rtl/sine_cosine_taylor_series_defines.svh @@
// Assertion macros shared by the sine/cosine block.
`ifndef SINE_COSINE_TAYLOR_SERIES_DEFINES_SVH
`define SINE_COSINE_TAYLOR_SERIES_DEFINES_SVH
`ifndef SYNTHESIS
// Condition must never hold outside reset.
`define SCT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sct assertion failed");
// Antecedent implies consequent in the same cycle.
`define SCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sct assertion failed");
`else
`define SCT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`define SCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/sct_pkg.sv @@
// Types and constants shared by the sine/cosine modules.
package sct_pkg;

  // fraction bits of the internal fixed-point format
  localparam int QF = 48;
  // width of the reduced angle magnitude in Q.48
  localparam int XW = 51;
  // 2*pi in unsigned Q8.56
  localparam logic [63:0] TWO_PI_Q56 = (64'h3243F6A8885A308D + 64'd4) >> 3;
  // depth of the queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW = 1;

  // reduced angle handed from front to back
  typedef struct packed {
    logic          neg;
    logic [XW-1:0] x;
  } sct_item_t;

  // multiply request to the shared multiplier
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } sct_mul_req_t;

  typedef enum logic {
    FR_IDLE,
    FR_REDUCE
  } sct_front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_X2,
    BK_FS,
    BK_TS,
    BK_FC,
    BK_TC,
    BK_DONE
  } sct_back_state_t;

endpackage

@@ rtl/sct_front.sv @@
// Front end: takes angles, folds them into +-2*pi, hands them to the queue.
module sct_front import sct_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic signed [31:0] in_angle,
  output logic               in_full,
  output logic               q_push,
  output sct_item_t          q_data,
  input  logic               q_full
);

  sct_front_state_t state_r, state_nxt;
  logic [63:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] abs_angle;
  logic [63:0] mag_rnd;

  // magnitude of the angle; the most negative code maps to 2^31
  assign abs_angle = in_angle[31] ? (32'd0 - $unsigned(in_angle)) : $unsigned(in_angle);
  assign mag_rnd   = mag_r + 64'd128;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
  end

  // one subtract of 2*pi per cycle, then round to Q.48 and push once the queue has room
  always_comb begin
    state_nxt   = state_r;
    mag_nxt     = mag_r;
    neg_nxt     = neg_r;
    in_full     = (state_r != FR_IDLE);
    q_push      = 1'b0;
    q_data.neg  = neg_r;
    q_data.x    = mag_rnd[XW+7:8];
    unique case (state_r)
      FR_IDLE: begin
        if (in_push) begin
          neg_nxt   = in_angle[31];
          mag_nxt   = {abs_angle, 32'd0};
          state_nxt = FR_REDUCE;
        end
      end
      FR_REDUCE: begin
        if (mag_r > TWO_PI_Q56) begin
          mag_nxt = mag_r - TWO_PI_Q56;
        end else if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = FR_IDLE;
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

endmodule

@@ rtl/sct_queue.sv @@
// Short queue between the front end and the series engine.
module sct_queue import sct_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  sct_item_t wr_data,
  output logic      full,
  input  logic      pop,
  output sct_item_t rd_data,
  output logic      empty
);

  sct_item_t      mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r;
  logic           do_push, do_pop;

  assign full    = (count_r == (QAW+1)'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ rtl/sct_mul.sv @@
// Shared Q.48 multiplier: one 32x32 partial product per cycle, rounded result.
module sct_mul import sct_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  sct_mul_req_t req,
  output logic         done,
  output logic [63:0]  p
);

  localparam logic [127:0] RND = 128'd1 << (QF - 1);

  logic [63:0]  a_r, b_r;
  logic [127:0] acc_r;
  logic [1:0]   cnt_r;
  logic         busy_r, done_r;
  logic [63:0]  pp;
  logic [1:0]   sh;
  logic [127:0] pp_ext;

  // partial product selected by the step count
  assign pp     = 64'(a_r[cnt_r[1]*32 +: 32]) * 64'(b_r[cnt_r[0]*32 +: 32]);
  assign sh     = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
  assign pp_ext = {64'd0, pp} << {sh, 5'd0};
  assign done   = done_r;
  assign p      = acc_r[QF+63:QF];

  // operands and accumulator
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= RND;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_ext;
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 2'd3);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 2'd3) busy_r <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/sct_back.sv @@
// Series engine: sums the sine and cosine Maclaurin series and holds the result.
module sct_back import sct_pkg::*; #(
  parameter int TERMS = 18
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  sct_item_t          q_data,
  output logic               q_pop,
  output sct_mul_req_t       mul_req,
  input  logic               mul_done,
  input  logic [63:0]        mul_p,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_sine,
  output logic signed [31:0] out_cosine
);

  localparam int KW = $clog2(TERMS);
  // table spans every value of the {k, bit} index
  localparam int NR = 2 ** (KW + 1);
  localparam logic [63:0] ONE_Q = 64'd1 << QF;

  // reciprocal of i*(i-1), Q.48, worked out at elaboration
  logic [47:0] recip [NR];
  for (genvar g = 0; g < NR; g++) begin : g_recip
    if (g < 2) begin : g_none
      assign recip[g] = '0;
    end else begin : g_val
      localparam longint unsigned D = longint'(g) * longint'(g - 1);
      localparam longint unsigned R = ((64'd1 << QF) + D / 2) / D;
      assign recip[g] = R[47:0];
    end
  end

  sct_back_state_t   state_r, state_nxt;
  logic [KW-1:0]     k_r, k_nxt, k_inc;
  logic              neg_r, neg_nxt;
  logic [63:0]       x2_r, x2_nxt;
  logic [63:0]       sterm_r, sterm_nxt, cterm_r, cterm_nxt;
  logic signed [63:0] ssum_r, ssum_nxt, csum_r, csum_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       sine_r, sine_nxt, cosine_r, cosine_nxt;
  logic [47:0]       r_s, r_c, r_s_next;

  // round Q.48 to Q2.30 away from zero, saturate to one, apply sign
  function automatic logic [31:0] to_out(input logic signed [63:0] s, input logic flip);
    logic        neg;
    logic [63:0] m;
    logic [63:0] r;
    neg = s[63] ^ flip;
    m   = s[63] ? (64'd0 - $unsigned(s)) : $unsigned(s);
    r   = (m + (64'd1 << (QF - 31))) >> (QF - 30);
    if (r > (64'd1 << 30)) r = 64'd1 << 30;
    if (neg) r = 64'd0 - r;
    return r[31:0];
  endfunction

  assign k_inc    = k_r + 1'b1;
  assign r_s      = recip[{k_r, 1'b1}];
  assign r_c      = recip[{k_r, 1'b0}];
  assign r_s_next = recip[{k_inc, 1'b1}];

  assign out_empty  = !out_valid_r;
  assign out_sine   = $signed(sine_r);
  assign out_cosine = $signed(cosine_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    neg_r    <= neg_nxt;
    x2_r     <= x2_nxt;
    sterm_r  <= sterm_nxt;
    cterm_r  <= cterm_nxt;
    ssum_r   <= ssum_nxt;
    csum_r   <= csum_nxt;
    sine_r   <= sine_nxt;
    cosine_r <= cosine_nxt;
  end

  // sequencer: x*x, then per term step factor and term for sine and cosine
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    neg_nxt       = neg_r;
    x2_nxt        = x2_r;
    sterm_nxt     = sterm_r;
    cterm_nxt     = cterm_r;
    ssum_nxt      = ssum_r;
    csum_nxt      = csum_r;
    sine_nxt      = sine_r;
    cosine_nxt    = cosine_r;
    out_valid_nxt = out_valid_r && !out_pop;
    q_pop         = 1'b0;
    mul_req.start = 1'b0;
    mul_req.a     = x2_r;
    mul_req.b     = 64'(r_s);
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop         = 1'b1;
          neg_nxt       = q_data.neg;
          sterm_nxt     = 64'(q_data.x);
          k_nxt         = KW'(1);
          mul_req.start = 1'b1;
          mul_req.a     = 64'(q_data.x);
          mul_req.b     = 64'(q_data.x);
          state_nxt     = BK_X2;
        end
      end
      BK_X2: begin
        if (mul_done) begin
          x2_nxt        = mul_p;
          cterm_nxt     = ONE_Q;
          ssum_nxt      = $signed(sterm_r);
          csum_nxt      = $signed(ONE_Q);
          mul_req.start = 1'b1;
          mul_req.a     = mul_p;
          state_nxt     = BK_FS;
        end
      end
      BK_FS: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = sterm_r;
          mul_req.b     = mul_p;
          state_nxt     = BK_TS;
        end
      end
      BK_TS: begin
        if (mul_done) begin
          sterm_nxt     = mul_p;
          ssum_nxt      = k_r[0] ? (ssum_r - $signed(mul_p)) : (ssum_r + $signed(mul_p));
          mul_req.start = 1'b1;
          mul_req.b     = 64'(r_c);
          state_nxt     = BK_FC;
        end
      end
      BK_FC: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = cterm_r;
          mul_req.b     = mul_p;
          state_nxt     = BK_TC;
        end
      end
      BK_TC: begin
        if (mul_done) begin
          cterm_nxt = mul_p;
          csum_nxt  = k_r[0] ? (csum_r - $signed(mul_p)) : (csum_r + $signed(mul_p));
          if (k_r == KW'(TERMS - 1)) begin
            state_nxt = BK_DONE;
          end else begin
            k_nxt         = k_inc;
            mul_req.start = 1'b1;
            mul_req.b     = 64'(r_s_next);
            state_nxt     = BK_FS;
          end
        end
      end
      BK_DONE: begin
        if (!out_valid_r) begin
          sine_nxt      = to_out(ssum_r, neg_r);
          cosine_nxt    = to_out(csum_r, 1'b0);
          out_valid_nxt = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

endmodule

@@ rtl/sine_cosine_taylor_series.sv @@
// Top level of the fixed-point sine/cosine block.
//
// Input channel: write an angle (radians, signed Q8.24) on in_angle and raise
// in_push; the beat is taken at a clock edge where in_full is low.
// Result channel: while out_empty is low, out_sine and out_cosine (signed
// Q2.30, clamped to +-1.0) carry the oldest result; pop it with out_pop.
// One result beat per input beat, in order.
// The front end folds the angle into +-2*pi with one subtract per cycle.
// The series engine runs every product through one 32x32 multiplier, four
// partial products per Q.48 product and four products per term, and it
// takes the next angle from the queue only once its result is loaded.
// A two-entry queue lets the front end reduce the next angle while the
// engine works, so throughput is set by the engine.
// Reset empties the queue and the result register and clears both sequencers.
// If the receiver does not pop, the finished result holds and the engine
// waits; further angles back up into the queue and then raise in_full.
`include "sine_cosine_taylor_series_defines.svh"
module sine_cosine_taylor_series import sct_pkg::*; #(
  parameter int TERMS = 18
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic signed [31:0] in_angle,
  output logic               in_full,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_sine,
  output logic signed [31:0] out_cosine
);

  logic         fq_push, q_full, q_pop, q_empty;
  sct_item_t    fq_data, q_data;
  sct_mul_req_t mul_req;
  logic         mul_done;
  logic [63:0]  mul_p;

  sct_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_angle (in_angle),
    .in_full  (in_full),
    .q_push   (fq_push),
    .q_data   (fq_data),
    .q_full   (q_full)
  );

  sct_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fq_push),
    .wr_data (fq_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  sct_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .done  (mul_done),
    .p     (mul_p)
  );

  sct_back #(
    .TERMS (TERMS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .mul_req    (mul_req),
    .mul_done   (mul_done),
    .mul_p      (mul_p),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_sine   (out_sine),
    .out_cosine (out_cosine)
  );

  // front never pushes into a full queue
  `SCT_ASSERT_NEVER(a_no_q_overflow, clk, rst_n, fq_push && q_full)
  // engine never pops an empty queue
  `SCT_ASSERT_NEVER(a_no_q_underflow, clk, rst_n, q_pop && q_empty)
  // results stay within plus or minus one
  `SCT_ASSERT_IMPL(a_sine_range, clk, rst_n, !out_empty,
    (out_sine <= 32'sd1073741824) && (out_sine >= -32'sd1073741824))
  `SCT_ASSERT_IMPL(a_cosine_range, clk, rst_n, !out_empty,
    (out_cosine <= 32'sd1073741824) && (out_cosine >= -32'sd1073741824))

endmodule
